// ===== rtl/clksld_pkg.sv =====
// ============================================================================
// clksld_pkg
// Shared constants, codes and small helper functions for the scanned-display
// clock: display sizes, register indexes, reset values and digit tables.
// ============================================================================
package clksld_pkg;

  // Display geometry
  localparam int DIGITS  = 4;
  localparam int COLUMNS = 8;

  localparam int DSEL_W = (DIGITS  > 1) ? $clog2(DIGITS)  : 1;
  localparam int CSEL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Word field widths
  localparam int PERIOD_W    = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int COL_INDEX_W = 3;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int SEC_W       = 6;

  // Configuration register indexes; timer slots use the same order
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SECOND = 3'd0,
    REG_SCAN   = 3'd1,
    REG_MATRIX = 3'd2,
    REG_DOT    = 3'd3,
    REG_BLINK  = 3'd4
  } cfg_reg_t;

  localparam int NUM_REGS = 5;

  // Input word kinds
  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  // Time of day after reset
  localparam logic [HOUR_W-1:0] HOUR_RESET = 5'd15;
  localparam logic [MIN_W-1:0]  MIN_RESET  = 6'd8;
  localparam logic [SEC_W-1:0]  SEC_RESET  = 6'd50;

  localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;
  localparam logic [MIN_W-1:0]  MINS_PER_HOUR = 6'd60;
  localparam logic [SEC_W-1:0]  SECS_PER_MIN  = 6'd60;

  localparam logic [6:0] SEG_BLANK = 7'h7F;

  // Active-low seven-segment patterns for 0..9
  localparam logic [6:0] SEG_CODE [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  // Period and timer value after reset, by register index
  function automatic logic [PERIOD_W-1:0] period_reset(input int idx);
    logic [PERIOD_W-1:0] v;
    v = '0;
    priority if (idx == int'(REG_SECOND)) v = 10'd100;
    else if (idx == int'(REG_SCAN))       v = 10'd25;
    else if (idx == int'(REG_MATRIX))     v = 10'd10;
    else if (idx == int'(REG_DOT))        v = 10'd100;
    else if (idx == int'(REG_BLINK))      v = 10'd100;
    else                                  v = '0;
    return v;
  endfunction

  // Matrix column pattern after reset; columns 0 and 7 start blank
  function automatic logic [7:0] column_reset(input int idx);
    logic [7:0] v;
    v = 8'h00;
    unique case (idx)
      1:       v = 8'hFC;
      2:       v = 8'h12;
      3:       v = 8'h11;
      4:       v = 8'h01;
      5:       v = 8'h12;
      6:       v = 8'hFC;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Tens digit of a value below 64, by compares
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    t = 4'd0;
    priority if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50)     t = 4'd5;
    else if (v >= 6'd40)     t = 4'd4;
    else if (v >= 6'd30)     t = 4'd3;
    else if (v >= 6'd20)     t = 4'd2;
    else if (v >= 6'd10)     t = 4'd1;
    else                     t = 4'd0;
    return t;
  endfunction

  // Units digit of a value below 64
  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [3:0] t;
    logic [6:0] tens_x10;
    logic [6:0] rem;
    t        = tens_of(v);
    // ten times the tens digit as 8t + 2t
    tens_x10 = {t, 3'b000} + {2'b00, t, 1'b0};
    rem      = {1'b0, v} - tens_x10;
    return rem[3:0];
  endfunction

endpackage

// ===== rtl/clock_with_scanned_led_displays.sv =====
// ============================================================================
// clock_with_scanned_led_displays
// Tick-driven 24-hour clock with a multiplexed four-digit seven-segment
// scanner, an LED matrix column scanner, a colon dot and a status LED.
// ============================================================================
//
//  channel | signals                               | direction | word
//  --------+---------------------------------------+-----------+-----------------
//  in      | in_valid, in_stall                    | into      | action, column
//  out     | out_valid, out_stall                  | out of    | pins and time
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | into      | period register
//
//  One word per cycle sustained while out_stall is low; a word passes from
//  acceptance through the input register, then through the update logic into
//  the state registers, which are also the result register.
//  Synchronous active-high reset restores the time 15:08:50 and all periods.
//  A stalled result holds; the input register still takes one more word.
//  Configuration writes are always ready and go straight into the period register.
// ----------------------------------------------------------------------------
module clock_with_scanned_led_displays (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic [clksld_pkg::COL_INDEX_W-1:0]    column_index,
  input  logic [7:0]                            column_data,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [6:0]                            segment_drive,
  output logic [clksld_pkg::DIGITS-1:0]         digit_enable,
  output logic                                  dot_level,
  output logic                                  status_led,
  output logic [7:0]                            row_drive,
  output logic [7:0]                            column_enable,
  output logic [clksld_pkg::HOUR_W-1:0]         hours,
  output logic [clksld_pkg::MIN_W-1:0]          minutes,
  output logic [clksld_pkg::SEC_W-1:0]          seconds,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [clksld_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [clksld_pkg::PERIOD_W-1:0]       cfg_data
);
  import clksld_pkg::*;

  // Input register
  logic                   in_q_valid;
  logic                   in_q_action;
  logic [COL_INDEX_W-1:0] in_q_index;
  logic [7:0]             in_q_data;

  // Period registers and timers
  logic [PERIOD_W-1:0] period [NUM_REGS];
  logic [PERIOD_W-1:0] timer [NUM_REGS];
  logic [PERIOD_W-1:0] timer_next [NUM_REGS];
  logic [NUM_REGS-1:0] fire;

  // Clock and display state
  logic [HOUR_W-1:0] hour_count, hour_next;
  logic [MIN_W-1:0]  minute_count, minute_next;
  logic [SEC_W-1:0]  second_count, second_next;
  logic [DSEL_W-1:0] digit_select, digit_select_next;
  logic [CSEL_W-1:0] column_select, column_select_next;
  logic [6:0]        segment_latch, segment_next;
  logic [DIGITS-1:0] enable_latch, enable_next;
  logic [7:0]        row_latch, row_next;
  logic [7:0]        column_latch, column_next;
  logic [3:0]        digit_value;
  logic              dot_state;
  logic              led_state;
  logic [7:0]        column_store [COLUMNS];

  logic advance;
  logic is_tick;

  // Handshakes
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign cfg_ready = 1'b1;
  assign is_tick   = (in_q_action == ACT_TICK);

  // Result fields come straight from the state registers
  assign segment_drive = segment_latch;
  assign digit_enable  = enable_latch;
  assign dot_level     = dot_state;
  assign status_led    = led_state;
  assign row_drive     = row_latch;
  assign column_enable = column_latch;
  assign hours         = hour_count;
  assign minutes       = minute_count;
  assign seconds       = second_count;

  // Timers: fire at one or below and reload, else count down
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      fire[i]       = (timer[i] <= PERIOD_W'(1));
      timer_next[i] = fire[i] ? period[i] : timer[i] - PERIOD_W'(1);
    end
  end

  // Time of day with carries
  always_comb begin
    logic [SEC_W-1:0] s_inc;
    logic [MIN_W-1:0] m_inc;
    logic [HOUR_W-1:0] h_inc;
    s_inc       = second_count + SEC_W'(1);
    m_inc       = minute_count;
    h_inc       = hour_count;
    second_next = second_count;
    minute_next = minute_count;
    hour_next   = hour_count;
    if (fire[REG_SECOND]) begin
      if (s_inc >= SECS_PER_MIN) begin
        s_inc = '0;
        m_inc = minute_count + MIN_W'(1);
      end
      if (m_inc >= MINS_PER_HOUR) begin
        m_inc = '0;
        h_inc = hour_count + HOUR_W'(1);
      end
      if (h_inc >= HOURS_PER_DAY) begin
        h_inc = '0;
      end
      second_next = s_inc;
      minute_next = m_inc;
      hour_next   = h_inc;
    end
  end

  // Digit scan: next digit shows the updated time
  always_comb begin
    if (int'(digit_select) == DIGITS - 1) begin
      digit_select_next = '0;
    end else begin
      digit_select_next = digit_select + DSEL_W'(1);
    end
    unique case (int'(digit_select_next))
      0:       digit_value = tens_of({1'b0, hour_next});
      1:       digit_value = units_of({1'b0, hour_next});
      2:       digit_value = tens_of(minute_next);
      3:       digit_value = units_of(minute_next);
      default: digit_value = 4'd0;
    endcase
    segment_next = (digit_value < 4'd10) ? SEG_CODE[digit_value] : SEG_BLANK;
    enable_next  = ~(DIGITS'(1) << digit_select_next);
  end

  // Matrix scan: show current column, then step
  always_comb begin
    if (int'(column_select) == COLUMNS - 1) begin
      column_select_next = '0;
    end else begin
      column_select_next = column_select + CSEL_W'(1);
    end
    row_next    = ~column_store[column_select];
    column_next = (int'(column_select) < 8) ? ~(8'd1 << column_select) : 8'hFF;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_q_action <= action;
      in_q_index  <= column_index;
      in_q_data   <= column_data;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Period registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        period[i] <= period_reset(i);
      end
    end else if (cfg_valid && (int'(cfg_index) < NUM_REGS)) begin
      period[cfg_index] <= cfg_data;
    end
  end

  // State update, one word per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        timer[i] <= period_reset(i);
      end
      for (int i = 0; i < COLUMNS; i++) begin
        column_store[i] <= column_reset(i);
      end
      hour_count    <= HOUR_RESET;
      minute_count  <= MIN_RESET;
      second_count  <= SEC_RESET;
      digit_select  <= '0;
      segment_latch <= SEG_CODE[tens_of({1'b0, HOUR_RESET})];
      enable_latch  <= ~DIGITS'(1);
      column_select <= '0;
      row_latch     <= 8'h00;
      column_latch  <= 8'h00;
      dot_state     <= 1'b0;
      led_state     <= 1'b0;
    end else if (advance) begin
      if (is_tick) begin
        for (int i = 0; i < NUM_REGS; i++) begin
          timer[i] <= timer_next[i];
        end
        if (fire[REG_MATRIX]) begin
          row_latch     <= row_next;
          column_latch  <= column_next;
          column_select <= column_select_next;
        end
        hour_count   <= hour_next;
        minute_count <= minute_next;
        second_count <= second_next;
        if (fire[REG_BLINK]) begin
          led_state <= ~led_state;
        end
        if (fire[REG_DOT]) begin
          dot_state <= ~dot_state;
        end
        if (fire[REG_SCAN]) begin
          digit_select  <= digit_select_next;
          segment_latch <= segment_next;
          enable_latch  <= enable_next;
        end
      end else if (int'(in_q_index) < COLUMNS) begin
        // column write touches only the store
        column_store[CSEL_W'(in_q_index)] <= in_q_data;
      end
    end
  end

endmodule
